@@ sv/lcrd_pkg.sv @@
package lcrd_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int POS_W     = 10;
    localparam int CNT_W     = 8;
    localparam int WIDTH_W   = 11;
    localparam int MINRUN_W  = 8;
    localparam int LINES_W   = 2;
    localparam int CFG_W     = 11;

    localparam logic [COL_W-1:0] RUN_LEN_MAX = COL_W'(MAX_WIDTH - 1);

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH = 1'b0,
        CFG_MIN_RUN     = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ACT_RIGHT  = 2'd0,
        ACT_CENTRE = 2'd1,
        ACT_LEFT   = 2'd2
    } t_steer;

    localparam logic [LINES_W-1:0] LINES_NONE = 2'd0;
    localparam logic [LINES_W-1:0] LINES_ONE  = 2'd1;
    localparam logic [LINES_W-1:0] LINES_TWO  = 2'd2;

    typedef struct packed {
        logic [LINES_W-1:0] lines;
        logic [POS_W-1:0]   pos0;
        logic [POS_W-1:0]   pos1;
    } t_frame_sum;

    typedef struct packed {
        logic             advance;
        logic             last;
        logic [CNT_W-1:0] count;
    } t_col_beat;

endpackage

@@ sv/lcrd_in_stage.sv @@
module lcrd_in_stage
    import lcrd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CNT_W-1:0] i_column_count,
    input  logic             i_last_column,
    input  logic             i_can_load,
    output logic             o_in_stall,
    output t_col_beat        o_beat
);

    logic             r_valid;
    logic             r_last;
    logic [CNT_W-1:0] r_count;
    logic             advance;

    // a last column needs room in the result register, any other goes on
    assign advance    = r_valid && (!r_last || i_can_load);
    assign o_in_stall = r_valid && !advance;

    assign o_beat.advance = advance;
    assign o_beat.last    = r_last;
    assign o_beat.count   = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_last  <= i_last_column;
            r_count <= i_column_count;
        end
    end

endmodule

@@ sv/lcrd_run_tracker.sv @@
module lcrd_run_tracker
    import lcrd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_col_beat           i_beat,
    input  logic [MINRUN_W-1:0] i_min_run,
    output t_frame_sum          o_sum
);

    logic             r_in_run;
    logic [COL_W-1:0] r_run_len;
    logic [1:0]       r_runs_done;
    logic [COL_W-1:0] r_centre [2];
    logic [COL_W-1:0] r_col;

    logic             n_in_run;
    logic [COL_W-1:0] n_run_len;
    logic [1:0]       n_runs_done;
    logic [COL_W-1:0] n_centre [2];
    logic [COL_W-1:0] centre;

    // column minus half the run, wrapping modulo the column range
    assign centre = r_col - (r_run_len >> 1);

    always_comb begin
        n_in_run    = r_in_run;
        n_run_len   = r_run_len;
        n_runs_done = r_runs_done;
        n_centre[0] = r_centre[0];
        n_centre[1] = r_centre[1];
        if (!r_runs_done[1]) begin
            if (i_beat.count != '0) begin
                n_in_run  = 1'b1;
                n_run_len = (r_run_len == RUN_LEN_MAX) ? r_run_len : r_run_len + 1'b1;
            end else if (r_in_run && (r_run_len > COL_W'(i_min_run))) begin
                n_centre[r_runs_done[0]] = centre;
                n_runs_done = r_runs_done + 2'd1;
                n_run_len   = '0;
                n_in_run    = 1'b0;
            end else begin
                n_in_run  = 1'b0;
                n_run_len = '0;
            end
        end
    end

    assign o_sum.lines = n_runs_done;
    assign o_sum.pos0  = (n_runs_done != LINES_NONE) ? POS_W'(n_centre[0]) : '0;
    assign o_sum.pos1  = (n_runs_done == LINES_TWO)  ? POS_W'(n_centre[1]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run    <= 1'b0;
            r_run_len   <= '0;
            r_runs_done <= '0;
            r_centre[0] <= '0;
            r_centre[1] <= '0;
            r_col       <= '0;
        end else if (i_beat.advance) begin
            if (i_beat.last) begin
                r_in_run    <= 1'b0;
                r_run_len   <= '0;
                r_runs_done <= '0;
                r_centre[0] <= '0;
                r_centre[1] <= '0;
                r_col       <= '0;
            end else begin
                r_in_run    <= n_in_run;
                r_run_len   <= n_run_len;
                r_runs_done <= n_runs_done;
                r_centre[0] <= n_centre[0];
                r_centre[1] <= n_centre[1];
                r_col       <= r_col + 1'b1;
            end
        end
    end

endmodule

@@ sv/lcrd_steer.sv @@
module lcrd_steer
    import lcrd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_frame_sum         i_sum,
    input  logic [WIDTH_W-1:0] i_image_width,
    input  logic               i_out_stall,
    output logic               o_can_load,
    output logic               o_out_valid,
    output logic [LINES_W-1:0] o_lines_found,
    output logic [1:0]         o_steer_action,
    output logic [POS_W-1:0]   o_first_line_pos,
    output logic [POS_W-1:0]   o_second_line_pos
);

    logic               r_out_valid;
    t_steer             r_action;
    t_steer             n_action;
    logic [LINES_W-1:0] r_lines;
    logic [POS_W-1:0]   r_pos0;
    logic [POS_W-1:0]   r_pos1;
    logic               left_of_centre;

    assign left_of_centre = i_sum.pos0 < POS_W'(i_image_width >> 1);
    assign o_can_load     = !r_out_valid || !i_out_stall;

    always_comb begin
        n_action = r_action;
        case (i_sum.lines)
            LINES_TWO: n_action = ACT_CENTRE;
            LINES_ONE: begin
                if (left_of_centre && r_action != ACT_LEFT) begin
                    n_action = ACT_RIGHT;
                end else if (r_action != ACT_RIGHT) begin
                    n_action = ACT_LEFT;
                end
            end
            default: n_action = r_action;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_action    <= ACT_CENTRE;
        end else if (i_load) begin
            r_out_valid <= 1'b1;
            r_action    <= n_action;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_load) begin
            r_lines <= i_sum.lines;
            r_pos0  <= i_sum.pos0;
            r_pos1  <= i_sum.pos1;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_lines_found     = r_lines;
    assign o_steer_action    = r_action;
    assign o_first_line_pos  = r_pos0;
    assign o_second_line_pos = r_pos1;

endmodule

@@ sv/lane_column_run_detector.sv @@
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+--------------------------------------
// in      | to block  | i_in_valid / o_in_stall | i_column_count, i_last_column
// out     | from block| o_out_valid/ i_out_stall| o_lines_found, o_steer_action,
//         |           |                         | o_first_line_pos, o_second_line_pos
// cfg     | to block  | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One column beat is taken every cycle while o_in_stall is low. A beat is registered
// in the input register, then processed by the run tracker; a frame result is loaded
// into the result register when its last column moves on from the input register.
// Only a last-column beat can wait: it holds in the input register while the
// result register is full and stalled, which raises o_in_stall.
// Reset is synchronous and active low; it clears the frame state, sets the
// steering action to centred and loads the default configuration.
module lane_column_run_detector
    import lcrd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CNT_W-1:0]   i_column_count,
    input  logic               i_last_column,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [LINES_W-1:0] o_lines_found,
    output logic [1:0]         o_steer_action,
    output logic [POS_W-1:0]   o_first_line_pos,
    output logic [POS_W-1:0]   o_second_line_pos,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    logic [WIDTH_W-1:0]  r_image_width;
    logic [MINRUN_W-1:0] r_min_run;
    t_col_beat           beat;
    t_frame_sum          sum;
    logic                can_load;

    // configuration registers; the user must write them only while the block is idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= WIDTH_W'(640);
            r_min_run     <= MINRUN_W'(2);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_MIN_RUN:     r_min_run     <= i_cfg_data[MINRUN_W-1:0];
                default:         r_min_run     <= r_min_run;
            endcase
        end
    end

    // register the incoming beat, holding a last column while the result register is blocked
    lcrd_in_stage u_in_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_column_count (i_column_count),
        .i_last_column  (i_last_column),
        .i_can_load     (can_load),
        .o_in_stall     (o_in_stall),
        .o_beat         (beat)
    );

    // track runs of occupied columns and their centres
    lcrd_run_tracker u_run_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (beat),
        .i_min_run (r_min_run),
        .o_sum     (sum)
    );

    // update the steering action and register the frame result
    lcrd_steer u_steer (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (beat.advance && beat.last),
        .i_sum             (sum),
        .i_image_width     (r_image_width),
        .i_out_stall       (i_out_stall),
        .o_can_load        (can_load),
        .o_out_valid       (o_out_valid),
        .o_lines_found     (o_lines_found),
        .o_steer_action    (o_steer_action),
        .o_first_line_pos  (o_first_line_pos),
        .o_second_line_pos (o_second_line_pos)
    );

    // a stall is only ever raised for a waiting last column
    a_stall_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (beat.last && o_out_valid && i_out_stall))
        else $error("input stalled without a blocked frame result");

    a_lines_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_lines_found != 2'd3))
        else $error("line count out of range");

    a_two_lines_centred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_lines_found == LINES_TWO) |-> (o_steer_action == ACT_CENTRE))
        else $error("two lines found but action not centred");

    a_no_line_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_lines_found == LINES_NONE)
            |-> (o_first_line_pos == '0 && o_second_line_pos == '0))
        else $error("line positions set with no line found");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import lcrd_pkg::*;

    localparam int QUIET_LIMIT  = 3000;  // cycles with no beat on any port
    localparam int DRAIN_CYCLES = 8;     // settle time once the last result has come
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off under pressure
    localparam int PHASE_COLS   = 56;    // minimum columns per random phase
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             last;
    } t_column_beat;

    typedef struct packed {
        logic [LINES_W-1:0] lines;
        t_steer             action;
        logic [POS_W-1:0]   first_pos;
        logic [POS_W-1:0]   second_pos;
    } t_frame_result;

    // DUT ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [CNT_W-1:0]   i_column_count = '0;
    logic               i_last_column = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [LINES_W-1:0] o_lines_found;
    logic [1:0]         o_steer_action;
    logic [POS_W-1:0]   o_first_line_pos;
    logic [POS_W-1:0]   o_second_line_pos;
    logic               i_cfg_we = 1'b0;
    logic [0:0]         i_cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    // Columns waiting to be driven and frame results waiting to arrive
    t_column_beat  column_q[$];
    t_frame_result frame_q[$];
    logic [CNT_W-1:0] pattern_q[$];

    // Mirror of the configuration registers
    logic [WIDTH_W-1:0]  cfg_width   = 11'd640;
    logic [MINRUN_W-1:0] cfg_min_run = 8'd2;

    // Run tracker state, mirrored column by column
    logic               trk_in_run  = 1'b0;
    logic [COL_W-1:0]   trk_run_len = '0;
    logic [1:0]         trk_runs    = '0;
    logic [POS_W-1:0]   trk_centre [2] = '{default: '0};
    logic [COL_W-1:0]   trk_col     = '0;
    t_steer             trk_action  = ACT_CENTRE;

    bit idle_on = 1'b0;
    int pushed_cols = 0;
    int err_count = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    bit stall_next;
    t_column_beat drv_beat;

    lane_column_run_detector i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_column_count    (i_column_count),
        .i_last_column     (i_last_column),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_lines_found     (o_lines_found),
        .o_steer_action    (o_steer_action),
        .o_first_line_pos  (o_first_line_pos),
        .o_second_line_pos (o_second_line_pos),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CNT_W-1:0] any_marked();
        return CNT_W'($urandom_range(1, 255));
    endfunction

    // Advance the run tracker by one column; queue a frame result on the last one
    task automatic track_column(logic [CNT_W-1:0] count, logic last);
        logic [COL_W-1:0] half;
        t_frame_result    res;
        if (trk_runs < 2) begin
            if (count != 0) begin
                trk_in_run = 1'b1;
                if (trk_run_len != RUN_LEN_MAX) trk_run_len = trk_run_len + 1'b1;
            end else if (trk_in_run && trk_run_len > cfg_min_run) begin
                // centre wraps modulo the column range
                half = trk_run_len >> 1;
                trk_centre[trk_runs[0]] = trk_col - half;
                trk_runs = trk_runs + 1'b1;
                trk_run_len = '0;
                trk_in_run = 1'b0;
            end else begin
                trk_in_run = 1'b0;
                trk_run_len = '0;
            end
        end
        if (!last) begin
            trk_col = trk_col + 1'b1;
        end else begin
            if (trk_runs == LINES_TWO) begin
                trk_action = ACT_CENTRE;
            end else if (trk_runs == LINES_ONE) begin
                if (trk_centre[0] < (cfg_width >> 1) && trk_action != ACT_LEFT)
                    trk_action = ACT_RIGHT;
                else if (trk_action != ACT_RIGHT)
                    trk_action = ACT_LEFT;
            end
            res.lines      = trk_runs;
            res.action     = trk_action;
            res.first_pos  = (trk_runs >= LINES_ONE) ? trk_centre[0] : '0;
            res.second_pos = (trk_runs >= LINES_TWO) ? trk_centre[1] : '0;
            frame_q = {frame_q, res};
            // start a new frame, keep the steering action
            trk_in_run = 1'b0;
            trk_run_len = '0;
            trk_runs = '0;
            trk_centre[0] = '0;
            trk_centre[1] = '0;
            trk_col = '0;
        end
    endtask

    task automatic check_frame();
        t_frame_result want;
        if (frame_q.size() == 0) begin
            err_count++;
            if (err_count <= REPORT_MAX)
                $display("ERROR %0t: frame result with none pending: lines %0d act %0d %s",
                         $time, o_lines_found, o_steer_action,
                         $sformatf("pos %0d/%0d", o_first_line_pos, o_second_line_pos));
        end else begin
            want = frame_q.pop_front();
            if (o_lines_found !== want.lines || o_steer_action !== want.action ||
                o_first_line_pos !== want.first_pos ||
                o_second_line_pos !== want.second_pos) begin
                err_count++;
                if (err_count <= REPORT_MAX)
                    $display("ERROR %0t: lines %0d/%0d act %0d/%0d pos0 %0d/%0d pos1 %0d/%0d %s",
                             $time, o_lines_found, want.lines, o_steer_action, want.action,
                             o_first_line_pos, want.first_pos, o_second_line_pos,
                             want.second_pos, "(got/exp)");
            end
        end
    endtask

    // Input side: predict on every accepted beat, hold while stalled, then gap or offer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) track_column(i_column_count, i_last_column);
            if (i_in_valid && o_in_stall) begin
                // hold the stalled beat
            end else if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (column_q.size() != 0) begin
                drv_beat = column_q.pop_front();
                i_in_valid     <= 1'b1;
                i_column_count <= drv_beat.count;
                i_last_column  <= drv_beat.last;
                tx_gap = idle_on ? pick_gap() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: check accepted results, stall at random or for a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_frame();
            if (hold_ack != hold_req) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                stall_next = 1'b1;
            end else begin
                rx_gap = idle_on ? pick_gap() : 0;
                stall_next = (rx_gap > 0);
                if (rx_gap > 0) rx_gap--;
            end
            i_out_stall <= stall_next;
        end
    end

    // Drop the run if no beat moves on any port for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("lane_column_run_detector regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_col(logic [CNT_W-1:0] count, logic last);
        t_column_beat b;
        b.count = count;
        b.last  = last;
        column_q = {column_q, b};
        pushed_cols++;
    endtask

    task automatic push_pattern();
        for (int k = 0; k < pattern_q.size(); k++)
            push_col(pattern_q[k], k == pattern_q.size() - 1);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) cfg_width = val[WIDTH_W-1:0];
        else cfg_min_run = val[MINRUN_W-1:0];
    endtask

    // Wait until every column is taken and every result has come, then let the block settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (column_q.size() != 0 || i_in_valid || frame_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic start_phase(int width, int min_run, bit idle);
        wait_drained();
        idle_on = idle;
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(width));
        // upper data bits are junk for the narrower register
        write_reg(CFG_MIN_RUN, {3'($urandom), MINRUN_W'(min_run)});
        @(negedge i_clk);
    endtask

    // Run lengths cluster around the threshold so both sides of it are hit
    function automatic int pick_run_len();
        int len;
        if ($urandom_range(0, 9) < 7) len = int'(cfg_min_run) + $urandom_range(0, 3) - 1;
        else len = $urandom_range(1, 2 * int'(cfg_min_run) + 6);
        return (len < 1) ? 1 : len;
    endfunction

    task automatic push_random_frame();
        int len;
        int n_runs;
        int open_len;
        if ($urandom_range(0, 99) < 12) begin
            // noise frame: scattered marks
            len = $urandom_range(1, 24);
            for (int k = 0; k < len; k++)
                push_col($urandom_range(0, 1) ? any_marked() : '0, k == len - 1);
        end else begin
            n_runs = $urandom_range(0, 3);
            repeat ($urandom_range(0, 2)) push_col('0, 1'b0);
            repeat (n_runs) begin
                len = pick_run_len();
                repeat (len) push_col(any_marked(), 1'b0);
                repeat ($urandom_range(1, 2)) push_col('0, 1'b0);
            end
            // sometimes leave a run open into the frame end
            open_len = ($urandom_range(0, 3) == 0)
                     ? $urandom_range(1, int'(cfg_min_run) + 3) : 0;
            repeat (open_len) push_col(any_marked(), 1'b0);
            push_col($urandom_range(0, 2) == 0 ? any_marked() : '0, 1'b1);
        end
    endtask

    initial begin
        int w;
        int m;
        bit idle;
        int start_cols;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: one short run left of centre
        pattern_q = '{8'd255, 8'd1, 8'd128, 8'd0};
        push_pattern();

        // Narrow image so both sides of centre are reachable
        start_phase(8, 2, 1'b0);
        // two lines, then marks after the second run are ignored
        pattern_q = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd1, 8'd1, 8'd1, 8'd0, 8'd77};
        push_pattern();
        // run as long as the minimum is dropped; one line right of centre
        pattern_q = '{8'd8, 8'd8, 8'd0, 8'd9, 8'd9, 8'd9, 8'd0};
        push_pattern();
        // one line left of centre while turning left; open run at frame end
        pattern_q = '{8'd5, 8'd5, 8'd5, 8'd0, 8'd7, 8'd7};
        push_pattern();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin w = 1024; m = 0; idle = 1'b1; end
                1: begin w = 1; m = 1; idle = 1'b1; end
                2: begin w = 0; m = 2; idle = 1'b1; end
                3: begin w = $urandom_range(1, 64) | 1; m = $urandom_range(0, 6); idle = 1'b1; end
                4: begin w = 640; m = 3; idle = 1'b0; end
                default: begin
                    w = $urandom_range(1, 1024);
                    m = $urandom_range(0, 8);
                    idle = 1'b1;
                end
            endcase
            start_phase(w, m, idle);
            start_cols = pushed_cols;
            while (pushed_cols - start_cols < PHASE_COLS) push_random_frame();
            // hold off the receiver while the sender keeps offering
            if (ph == 4) hold_req = hold_req + 1;
        end

        // Widest image, highest threshold: saturate the run and wrap the column index
        start_phase(1024, 255, 1'b1);
        repeat (1030) push_col(any_marked(), 1'b0);
        push_col('0, 1'b0);
        push_col('0, 1'b1);
        repeat (3) push_random_frame();

        wait_drained();
        if (err_count == 0)
            $display("lane_column_run_detector regression: pass");
        else
            $display("lane_column_run_detector regression: fail");
        $finish;
    end

endmodule
